// ----- src/binary_thinning_pixel_decision_macros.svh -----
// Assertion macros for the checker file of the pixel decision block.
`ifndef BINARY_THINNING_PIXEL_DECISION_MACROS_SVH
`define BINARY_THINNING_PIXEL_DECISION_MACROS_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define BTPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on the following edge.
`define BTPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/btpd_pkg.sv -----
// Package of constants and helpers for the thinning pixel decision.
package btpd_pkg;

  localparam int unsigned WinW  = 25;
  localparam int unsigned RingW = 8;

  typedef logic [WinW-1:0]  win_t;
  typedef logic [RingW-1:0] ring_t;

  function automatic win_t px(input int unsigned r, input int unsigned c);
    px = win_t'(1) << (5 * r + c);
  endfunction

  function automatic logic hit(input win_t w, input win_t m, input win_t p);
    hit = ((w & m) == p);
  endfunction

  // Restore templates A and B
  localparam win_t TA_MASK = px(2,1) | px(2,3) | px(2,4) | px(3,2);
  localparam win_t TA_PAT  = px(2,3) | px(3,2);
  localparam win_t TB_MASK = px(1,2) | px(2,3) | px(3,2) | px(4,2);
  localparam win_t TB_PAT  = px(2,3) | px(3,2);

  // Deletion templates D to M
  localparam win_t TD_MASK = px(0,1) | px(0,2) | px(0,3) | px(1,1) | px(1,2) | px(1,3)
                           | px(2,1) | px(2,3) | px(3,2) | px(3,3);
  localparam win_t TD_PAT  = px(1,2) | px(2,3) | px(3,2) | px(3,3);
  localparam win_t TE_MASK = px(1,0) | px(1,1) | px(1,2) | px(2,0) | px(2,1) | px(2,3)
                           | px(3,0) | px(3,1) | px(3,2) | px(3,3);
  localparam win_t TE_PAT  = px(2,1) | px(2,3) | px(3,2) | px(3,3);
  localparam win_t SIDE_MASK = px(2,4) | px(3,4) | px(4,2) | px(4,3);
  localparam win_t TF_MASK = px(1,0) | px(1,1) | px(1,2) | px(1,3) | px(2,0) | px(2,1)
                           | px(2,3) | px(3,0) | px(3,1) | px(3,2);
  localparam win_t TF_PAT  = px(1,2) | px(1,3) | px(2,1) | px(2,3);
  localparam win_t TG_MASK = px(1,1) | px(1,2) | px(1,3) | px(1,4) | px(2,1) | px(2,3)
                           | px(2,4) | px(3,2) | px(3,3) | px(3,4);
  localparam win_t TG_PAT  = px(1,1) | px(1,2) | px(2,1) | px(2,3);
  localparam win_t TH_MASK = px(1,2) | px(1,3) | px(1,4) | px(2,1) | px(2,3) | px(2,4)
                           | px(3,1) | px(3,2) | px(3,3) | px(3,4);
  localparam win_t TH_PAT  = px(2,1) | px(2,3) | px(3,1) | px(3,2);
  localparam win_t TI_MASK = px(0,1) | px(0,2) | px(0,3) | px(1,1) | px(1,2) | px(1,3)
                           | px(2,1) | px(2,3) | px(3,1) | px(3,2);
  localparam win_t TI_PAT  = px(1,2) | px(2,1) | px(3,1) | px(3,2);
  localparam win_t TJ_MASK = px(1,2) | px(1,3) | px(2,1) | px(2,3) | px(3,1) | px(3,2)
                           | px(3,3) | px(4,1) | px(4,2) | px(4,3);
  localparam win_t TJ_PAT  = px(1,2) | px(1,3) | px(2,3) | px(3,2);
  localparam win_t TK_MASK = px(1,1) | px(1,2) | px(2,1) | px(2,3) | px(3,1) | px(3,2)
                           | px(3,3) | px(4,1) | px(4,2) | px(4,3);
  localparam win_t TK_PAT  = px(1,1) | px(1,2) | px(2,1) | px(3,2);
  localparam win_t TLM_MASK = px(1,1) | px(1,2) | px(1,3) | px(2,1) | px(2,3) | px(3,1)
                            | px(3,2) | px(3,3);
  localparam win_t TL_PAT  = px(1,1) | px(1,2) | px(2,3) | px(3,3);
  localparam win_t TM_PAT  = px(1,2) | px(1,3) | px(2,1) | px(3,1);

  // Staircase masks over the neighbour ring (P1 at bit 0)
  localparam int unsigned NumStair = 4;
  localparam ring_t STAIR_MASK [NumStair] = '{
    ring_t'((1 << 5) | (1 << 2) | (1 << 0)),
    ring_t'((1 << 7) | (1 << 4) | (1 << 2)),
    ring_t'((1 << 1) | (1 << 6) | (1 << 4)),
    ring_t'((1 << 3) | (1 << 0) | (1 << 6))
  };
  localparam ring_t STAIR_PAT [NumStair] = '{
    ring_t'((1 << 2) | (1 << 0)),
    ring_t'((1 << 4) | (1 << 2)),
    ring_t'((1 << 6) | (1 << 4)),
    ring_t'((1 << 0) | (1 << 6))
  };

endpackage

// ----- src/binary_thinning_pixel_decision.sv -----
// Top level: per-pixel delete decision of a parallel thinning pass.
// Usage
// - Item channel: drive window_i with a 5x5 binary window (bit 5*row+col,
//   centre at bit 12, corners ignored) and pulse start_i. A beat is taken at
//   any edge with start_i high and busy_o low; busy_o is always low, so a new
//   window may be offered on every clock.
// - Result channel: done_o is high for exactly one cycle and delete_pixel_o
//   holds the decision in that cycle. The receiver cannot stall; a result
//   that is not sampled in its cycle is gone.
// - Config channel: cfg_valid_i/cfg_ready_o write pass_mode (cfg_pass_mode_i).
//   cfg_ready_o is always high. Mode 0 is the thinning deletion test, mode 1
//   the staircase clean-up test. Write it only while no window is in flight.
// Timing
// - Datapath: an input register, then the template match and ring
//   counts in one combinational stage, then the result register.
// - Throughput one window per cycle; the single decision stage sets it.
// Reset
// - rst_ni low clears both valid flags (no result pending) and returns
//   pass_mode to 0.
module binary_thinning_pixel_decision (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  btpd_pkg::win_t       window_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_pass_mode_i,
  output logic                 done_o,
  output logic                 delete_pixel_o
);
  import btpd_pkg::*;

  logic  in_vld_q, out_vld_q, pass_mode_q;
  win_t  window_q;
  logic  delete_q, delete_d;

  ring_t       ring, rot, rise;
  logic [3:0]  cnt_a, cnt_b;
  logic [2:0]  cnt_side;
  logic        side_ok, t_d, restore, any_tmpl, thin_del, stair_del;
  logic [NumStair-1:0] stair_hit;
  win_t        side_bits;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Control: valid pipeline and the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      pass_mode_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i && !busy_o;
      out_vld_q <= in_vld_q;
      if (cfg_valid_i && cfg_ready_o) begin
        pass_mode_q <= cfg_pass_mode_i;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      window_q <= window_i;
    end
    if (in_vld_q) begin
      delete_q <= delete_d;
    end
  end

  // Neighbour ring, clockwise from the pixel above
  assign ring = {window_q[6], window_q[11], window_q[16], window_q[17],
                 window_q[18], window_q[13], window_q[8], window_q[7]};
  assign rot  = {ring[RingW-2:0], ring[RingW-1]};
  // 0-to-1 transitions round the ring
  assign rise = ~ring & rot;
  assign side_bits = window_q & SIDE_MASK;

  always_comb begin
    cnt_a    = '0;
    cnt_b    = '0;
    cnt_side = '0;
    for (int unsigned i = 0; i < RingW; i++) begin
      cnt_a = cnt_a + 4'(rise[i]);
      cnt_b = cnt_b + 4'(ring[i]);
    end
    for (int unsigned i = 0; i < WinW; i++) begin
      cnt_side = cnt_side + 3'(side_bits[i]);
    end
  end

  assign side_ok = (cnt_side >= 3'd2);
  assign t_d     = hit(window_q, TD_MASK, TD_PAT) && side_ok;
  assign restore = hit(window_q, TA_MASK, TA_PAT) || hit(window_q, TB_MASK, TB_PAT);
  assign any_tmpl = t_d
                 || (hit(window_q, TE_MASK, TE_PAT) && side_ok)
                 || hit(window_q, TF_MASK, TF_PAT)
                 || hit(window_q, TG_MASK, TG_PAT)
                 || hit(window_q, TH_MASK, TH_PAT)
                 || hit(window_q, TI_MASK, TI_PAT)
                 || hit(window_q, TJ_MASK, TJ_PAT)
                 || hit(window_q, TK_MASK, TK_PAT)
                 || hit(window_q, TLM_MASK, TL_PAT)
                 || hit(window_q, TLM_MASK, TM_PAT);

  // Thinning: background centre always kept
  always_comb begin
    thin_del = 1'b0;
    if (window_q[12]) begin
      if (cnt_a == 4'd1 && cnt_b >= 4'd2 && cnt_b <= 4'd6) begin
        thin_del = !restore || t_d;
      end else if (cnt_a == 4'd2 && (cnt_b == 4'd4 || cnt_b == 4'd5)) begin
        thin_del = any_tmpl;
      end
    end
  end

  // Staircase clean-up: centre not examined
  always_comb begin
    for (int unsigned i = 0; i < NumStair; i++) begin
      stair_hit[i] = ((ring & STAIR_MASK[i]) == STAIR_PAT[i]);
    end
  end
  assign stair_del = |stair_hit;

  assign delete_d       = pass_mode_q ? stair_del : thin_del;
  assign done_o         = out_vld_q;
  assign delete_pixel_o = delete_q;

endmodule

// ----- src/btpd_checker.sv -----
// Port-level checker for the pixel decision block, with its bind.
`include "binary_thinning_pixel_decision_macros.svh"

module btpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [24:0] window_i,
  input logic        done_o,
  input logic        delete_pixel_o
);

  logic ring_empty;
  assign ring_empty = !(window_i[6] || window_i[7] || window_i[8] || window_i[11]
                     || window_i[13] || window_i[16] || window_i[17] || window_i[18]);

  // every accepted beat yields a result once through the input and result registers
  `BTPD_ASSERT_NEXT(a_beat_gives_result, start_i && !busy_o, ##1 done_o, "result missing")
  // no result without an earlier accepted beat
  `BTPD_ASSERT_SAME(a_no_spurious, done_o, $past(start_i && !busy_o, 2), "spurious result")
  // an isolated pixel is never removed in either mode
  `BTPD_ASSERT_SAME(a_isolated_kept, done_o && $past(start_i && !busy_o && ring_empty, 2),
                    !delete_pixel_o, "isolated pixel deleted")

endmodule

bind binary_thinning_pixel_decision btpd_checker u_btpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .window_i       (window_i),
  .done_o         (done_o),
  .delete_pixel_o (delete_pixel_o)
);
